// File: src/pwmsas_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmsas_pkg
// Shared types and constants for the PWM stage arming supervisor.
// ----------------------------------------------------------------------------
package pwmsas_pkg;

  localparam int unsigned DutyW   = 10;
  localparam int unsigned PeriodW = 16;
  localparam int unsigned ProdW   = PeriodW + DutyW;   // period * (1000 - duty)
  localparam int unsigned RecipW  = 27;
  localparam int unsigned RecipSh = 36;
  localparam int unsigned FullW   = ProdW + RecipW;    // product times reciprocal

  localparam logic [DutyW-1:0]   DUTY_FULL = 10'd1000;
  // ceil(2^36 / 1000): exact floor division for any product below 2^26
  localparam logic [RecipW-1:0]  RECIP_1000 = 27'd68719477;

  localparam logic [DutyW-1:0]   MIN_DUTY_RST  = 10'd50;
  localparam logic [DutyW-1:0]   MAX_DUTY_RST  = 10'd900;
  localparam logic [DutyW-1:0]   INIT_DUTY_RST = 10'd100;
  localparam logic [PeriodW-1:0] PERIOD_RST    = 16'd5000;

  typedef enum logic [2:0] {
    MODE_BOOT      = 3'd0,
    MODE_SAFE_INIT = 3'd1,
    MODE_READY     = 3'd2,
    MODE_RUNNING   = 3'd3,
    MODE_FAULT     = 3'd4
  } mode_e;

  typedef enum logic [1:0] {
    REQ_SERVICE   = 2'd0,
    REQ_SAFE_INIT = 2'd1,
    REQ_PWM_INIT  = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    CFG_MIN_DUTY  = 2'd0,
    CFG_MAX_DUTY  = 2'd1,
    CFG_INIT_DUTY = 2'd2,
    CFG_PERIOD    = 2'd3
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]       req_type;
    logic             arm_request;
    logic             stop_request;
    logic [DutyW-1:0] duty_command;
    logic             trip_source_active;
  } in_word_t;

  typedef struct packed {
    logic [2:0]         stage_state;
    logic               fault_code;
    logic [DutyW-1:0]   requested_duty;
    logic [DutyW-1:0]   applied_duty;
    logic [PeriodW-1:0] compare_value;
    logic               trip_flag;
    logic               buffer_enable_n;
  } out_word_t;

  typedef struct packed {
    logic [DutyW-1:0]   min_duty;
    logic [DutyW-1:0]   max_duty;
    logic [DutyW-1:0]   initial_duty;
    logic [PeriodW-1:0] period_counts;
  } cfg_t;

  typedef struct packed {
    mode_e              mode;
    logic               fault;
    logic [DutyW-1:0]   last_req;
    logic [DutyW-1:0]   last_app;
    logic [PeriodW-1:0] cmp;
    logic               trip;
    logic               buf_n;
  } sup_state_t;

endpackage

// File: src/pwmsas_decide.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwmsas_decide
// Next supervisor state for one request word, incl. compare scaling.
// ----------------------------------------------------------------------------
module pwmsas_decide (
  input  pwmsas_pkg::sup_state_t             state_i,
  input  pwmsas_pkg::in_word_t               item_i,
  input  pwmsas_pkg::cfg_t                   cfg_i,
  input  logic [pwmsas_pkg::ProdW-1:0]       prod_i,
  output pwmsas_pkg::sup_state_t             state_o
);
  import pwmsas_pkg::*;

  logic [FullW-1:0]   scaled;
  logic [PeriodW-1:0] quot;
  logic [DutyW-1:0]   duty_sel;
  logic               duty_bad;
  logic               ok;

  // divide by 1000 via reciprocal
  assign scaled = {{RecipW{1'b0}}, prod_i} * {{ProdW{1'b0}}, RECIP_1000};
  assign quot   = scaled[RecipSh +: PeriodW];

  assign duty_sel = (req_e'(item_i.req_type) == REQ_PWM_INIT) ? cfg_i.initial_duty
                                                              : item_i.duty_command;
  assign duty_bad = (duty_sel < cfg_i.min_duty) || (duty_sel > cfg_i.max_duty) ||
                    (duty_sel > DUTY_FULL);

  always_comb begin
    state_o = state_i;
    ok      = 1'b0;
    case (req_e'(item_i.req_type))
      REQ_SAFE_INIT: begin
        state_o.buf_n = 1'b1;
        state_o.mode  = MODE_SAFE_INIT;
        state_o.fault = 1'b0;
      end
      REQ_PWM_INIT: begin
        state_o.last_req = duty_sel;
        if (duty_bad) begin
          state_o.trip  = 1'b1;
          state_o.buf_n = 1'b1;
          state_o.fault = 1'b1;
          state_o.mode  = MODE_FAULT;
        end else begin
          state_o.cmp      = quot;
          state_o.last_app = duty_sel;
          state_o.trip     = 1'b1;
          state_o.buf_n    = 1'b1;
          state_o.mode     = MODE_READY;
        end
      end
      REQ_SERVICE: begin
        if (state_i.mode == MODE_FAULT) begin
          state_o.buf_n = 1'b1;
        end else if (item_i.stop_request) begin
          state_o.trip  = 1'b1;
          state_o.buf_n = 1'b1;
          state_o.mode  = MODE_READY;
        end else begin
          if (duty_sel == state_i.last_req) begin
            ok = 1'b1;
          end else begin
            state_o.last_req = duty_sel;
            if (duty_bad) begin
              state_o.trip  = 1'b1;
              state_o.buf_n = 1'b1;
              state_o.fault = 1'b1;
              state_o.mode  = MODE_FAULT;
            end else begin
              state_o.cmp      = quot;
              state_o.last_app = duty_sel;
              ok               = 1'b1;
            end
          end
          if (ok && item_i.arm_request && (state_i.mode == MODE_READY)) begin
            state_o.trip = item_i.trip_source_active;
            if (!item_i.trip_source_active) begin
              state_o.buf_n = 1'b0;
              state_o.mode  = MODE_RUNNING;
            end else begin
              state_o.buf_n = 1'b1;
            end
          end
        end
      end
      default: begin
        // unused request code: state unchanged
      end
    endcase
  end

endmodule

// File: src/pwm_stage_arming_supervisor_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_stage_arming_supervisor_unit
// Arming supervisor for a half-bridge PWM stage: mode tracking, duty check,
// compare value and trip / buffer-enable control.
// ----------------------------------------------------------------------------
// Use:
//  - Request words enter on in_valid_i / in_stall_o / in_word_i; one status
//    word per request leaves on out_valid_o / out_stall_i / out_word_o,
//    reporting the supervisor state after that request.
//  - A word passes the input register, then the state register. Throughput
//    is one word per cycle unless the receiver stalls: the input register
//    computes period * (1000 - duty), the state register (also the output
//    register) takes the decision and the reciprocal scaling by 1/1000.
//  - Limits, initial duty and period are written through cfg_we_i /
//    cfg_index_i / cfg_data_i while no request is in flight.
//  - Reset: boot mode, no fault, requested/applied duty 100 permille,
//    compare 0, trip clear, buffer disabled; registers at their defaults.
//  - If the receiver stalls, the status word holds, the input register keeps
//    one further word, and in_stall_o rises once both are occupied.
// ----------------------------------------------------------------------------
module pwm_stage_arming_supervisor_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  pwmsas_pkg::in_word_t                in_word_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output pwmsas_pkg::out_word_t               out_word_o,
  input  logic                                cfg_we_i,
  input  logic [1:0]                          cfg_index_i,
  input  logic [pwmsas_pkg::PeriodW-1:0]      cfg_data_i
);
  import pwmsas_pkg::*;

  // configuration registers
  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_duty      <= MIN_DUTY_RST;
      cfg_q.max_duty      <= MAX_DUTY_RST;
      cfg_q.initial_duty  <= INIT_DUTY_RST;
      cfg_q.period_counts <= PERIOD_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_MIN_DUTY:  cfg_q.min_duty      <= cfg_data_i[DutyW-1:0];
        CFG_MAX_DUTY:  cfg_q.max_duty      <= cfg_data_i[DutyW-1:0];
        CFG_INIT_DUTY: cfg_q.initial_duty  <= cfg_data_i[DutyW-1:0];
        CFG_PERIOD:    cfg_q.period_counts <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  // handshake: the state register moves when a word is held and the output side is free
  logic in_valid_q;
  logic out_valid_q;
  logic advance;
  logic in_take;

  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_take    = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_take) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input stage: word plus the compare product for the duty it would apply
  in_word_t          item_q;
  logic [ProdW-1:0]  prod_q;
  logic [ProdW-1:0]  prod_d;
  logic [DutyW-1:0]  cap_duty;
  logic [DutyW-1:0]  cap_diff;

  // the PWM init request applies the configured initial duty
  assign cap_duty = (req_e'(in_word_i.req_type) == REQ_PWM_INIT) ? cfg_q.initial_duty
                                                                 : in_word_i.duty_command;
  // wraps for duty above full scale; such a duty is rejected anyway
  assign cap_diff = DUTY_FULL - cap_duty;
  assign prod_d   = {{DutyW{1'b0}}, cfg_q.period_counts} * {{PeriodW{1'b0}}, cap_diff};

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      item_q <= in_word_i;
      prod_q <= prod_d;
    end
  end

  // supervisor state, doubles as the output register
  sup_state_t state_q;
  sup_state_t state_d;

  pwmsas_decide u_decide (
    .state_i (state_q),
    .item_i  (item_q),
    .cfg_i   (cfg_q),
    .prod_i  (prod_q),
    .state_o (state_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= MODE_BOOT;
      state_q.fault    <= 1'b0;
      state_q.last_req <= INIT_DUTY_RST;
      state_q.last_app <= INIT_DUTY_RST;
      state_q.cmp      <= '0;
      state_q.trip     <= 1'b0;
      state_q.buf_n    <= 1'b1;
    end else if (advance) begin
      state_q <= state_d;
    end
  end

  assign out_valid_o                = out_valid_q;
  assign out_word_o.stage_state     = state_q.mode;
  assign out_word_o.fault_code      = state_q.fault;
  assign out_word_o.requested_duty  = state_q.last_req;
  assign out_word_o.applied_duty    = state_q.last_app;
  assign out_word_o.compare_value   = state_q.cmp;
  assign out_word_o.trip_flag       = state_q.trip;
  assign out_word_o.buffer_enable_n = state_q.buf_n;

`ifndef SYNTHESIS
  // buffer only enabled while running
  a_buf_running: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !state_q.buf_n |-> (state_q.mode == MODE_RUNNING))
    else $error("buffer enabled outside running");

  // running implies trip flag clear
  a_run_no_trip: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_RUNNING) |-> !state_q.trip)
    else $error("running with trip flag set");

  // fault mode keeps the fault latched
  a_fault_latched: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q.mode == MODE_FAULT) |-> state_q.fault)
    else $error("fault mode without fault code");

  // status word only changes when a request is processed
  a_state_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(state_q))
    else $error("state changed without a request");

  // a full pipe against a stalled receiver refuses new words
  a_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_q && out_valid_q && out_stall_i) |-> in_stall_o)
    else $error("input accepted while pipe is blocked");
`endif

endmodule

// File: bench/pwm_stage_arming_supervisor_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pwm_stage_arming_supervisor_unit_tb
// Self-checking bench for the PWM stage arming supervisor. A directed table
// walks boot, init, arming, stop and fault recovery under the default limits.
// Random phases follow, each under its own limit setting. Each status word
// is checked field by field against a typed-in word or the in-bench model.
// ----------------------------------------------------------------------------
module pwm_stage_arming_supervisor_unit_tb;
  import pwmsas_pkg::*;

  localparam logic [1:0] REQ_UNUSED       = 2'd3;
  localparam logic       FAULT_NONE       = 1'b0;
  localparam logic       FAULT_DUTY_RANGE = 1'b1;
  localparam int         PHASE_WORDS      = 107;
  localparam int         QUIET_LIMIT      = 3000;

  typedef struct packed {
    in_word_t  req;
    logic      typed;  // 1: status word below is typed in, 0: from the model
    out_word_t want;
  } dir_row_t;

  // Default limits: min 50, max 900, initial 100, period 5000.
  localparam dir_row_t DIRECTED [25] = '{
    '{'{REQ_SERVICE,   0, 0,  100, 0}, 1, '{MODE_BOOT,      0,  100, 100,    0, 0, 1}},
    '{'{REQ_UNUSED,    1, 1, 1023, 1}, 1, '{MODE_BOOT,      0,  100, 100,    0, 0, 1}},
    '{'{REQ_SERVICE,   1, 0,  100, 0}, 1, '{MODE_BOOT,      0,  100, 100,    0, 0, 1}},
    '{'{REQ_SAFE_INIT, 0, 0,    0, 0}, 1, '{MODE_SAFE_INIT, 0,  100, 100,    0, 0, 1}},
    '{'{REQ_PWM_INIT,  0, 0,    0, 0}, 1, '{MODE_READY,     0,  100, 100, 4500, 1, 1}},
    '{'{REQ_SERVICE,   1, 0,  100, 1}, 1, '{MODE_READY,     0,  100, 100, 4500, 1, 1}},
    '{'{REQ_SERVICE,   1, 0,  100, 0}, 1, '{MODE_RUNNING,   0,  100, 100, 4500, 0, 0}},
    '{'{REQ_SERVICE,   0, 0,  900, 0}, 1, '{MODE_RUNNING,   0,  900, 900,  500, 0, 0}},
    '{'{REQ_SERVICE,   0, 0,   50, 0}, 1, '{MODE_RUNNING,   0,   50,  50, 4750, 0, 0}},
    '{'{REQ_SERVICE,   1, 0,  333, 0}, 0, '0},
    '{'{REQ_SERVICE,   0, 1,  333, 0}, 0, '0},
    '{'{REQ_SERVICE,   1, 0,  333, 0}, 0, '0},
    '{'{REQ_SERVICE,   0, 0, 1023, 0}, 1, '{MODE_FAULT,     1, 1023, 333, 3335, 1, 1}},
    '{'{REQ_SERVICE,   1, 1,    0, 1}, 1, '{MODE_FAULT,     1, 1023, 333, 3335, 1, 1}},
    '{'{REQ_PWM_INIT,  0, 0,    0, 0}, 1, '{MODE_READY,     1,  100, 100, 4500, 1, 1}},
    '{'{REQ_SAFE_INIT, 0, 0,    0, 0}, 1, '{MODE_SAFE_INIT, 0,  100, 100, 4500, 1, 1}},
    '{'{REQ_SERVICE,   0, 1,  100, 0}, 1, '{MODE_READY,     0,  100, 100, 4500, 1, 1}},
    '{'{REQ_SERVICE,   0, 0,   49, 0}, 1, '{MODE_FAULT,     1,   49, 100, 4500, 1, 1}},
    '{'{REQ_SAFE_INIT, 0, 0,    0, 0}, 0, '0},
    '{'{REQ_SERVICE,   0, 0,    0, 0}, 1, '{MODE_FAULT,     1,    0, 100, 4500, 1, 1}},
    '{'{REQ_SAFE_INIT, 0, 0,    0, 0}, 0, '0},
    '{'{REQ_SERVICE,   0, 0,  901, 0}, 1, '{MODE_FAULT,     1,  901, 100, 4500, 1, 1}},
    '{'{REQ_SAFE_INIT, 0, 0,    0, 0}, 0, '0},
    '{'{REQ_SERVICE,   1, 0,  500, 0}, 0, '0},
    '{'{REQ_SERVICE,   0, 0, 1000, 0}, 1, '{MODE_FAULT,     1, 1000, 500, 2500, 1, 1}}
  };

  // Fixed limit settings: wide open, max above full scale, crossed limits,
  // zero period, single legal duty, and an initial duty out of range.
  localparam cfg_t PHASE_LIMITS [6] = '{
    '{   0, 1000, 1000, 65535},
    '{   0, 1023,    0,     1},
    '{ 600,  400,  500,  5000},
    '{   0, 1000,  500,     0},
    '{1000, 1000, 1000, 65535},
    '{  50,  900, 1023, 20000}
  };

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_word_t  in_word_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_word_t out_word_o;
  logic      cfg_we_i    = 1'b0;
  logic [1:0]         cfg_index_i = CFG_MIN_DUTY;
  logic [PeriodW-1:0] cfg_data_i  = '0;

  pwm_stage_arming_supervisor_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // --------------------------------------------------------------------------
  // Supervisor model: limit copy and stage state, advanced per accepted word
  // --------------------------------------------------------------------------
  cfg_t       lim   = '{MIN_DUTY_RST, MAX_DUTY_RST, INIT_DUTY_RST, PERIOD_RST};
  sup_state_t stage = '{MODE_BOOT, FAULT_NONE, 10'd100, 10'd100, 16'd0, 1'b0, 1'b1};

  out_word_t status_due [$];
  int        mismatches = 0;
  int        words_seen = 0;
  int        burst_left = 0;

  // Forced safe state: trip set, buffer off; a range fault also latches.
  function automatic void trip_stage(bit latch_fault);
    stage.trip  = 1'b1;
    stage.buf_n = 1'b1;
    if (latch_fault) begin
      stage.fault = FAULT_DUTY_RANGE;
      stage.mode  = MODE_FAULT;
    end else if (stage.mode != MODE_FAULT) begin
      stage.mode = MODE_READY;
    end
  endfunction

  // Range check and compare scaling; anything above full scale is rejected
  // whatever the max limit says.
  function automatic bit offer_duty(logic [DutyW-1:0] duty);
    int unsigned scaled;
    stage.last_req = duty;
    if (duty < lim.min_duty || duty > lim.max_duty || duty > DUTY_FULL) begin
      trip_stage(1'b1);
      return 1'b0;
    end
    scaled = 32'(lim.period_counts) * (32'(DUTY_FULL) - 32'(duty)) / 32'(DUTY_FULL);
    stage.cmp      = scaled[PeriodW-1:0];
    stage.last_app = duty;
    return 1'b1;
  endfunction

  function automatic out_word_t stage_after(in_word_t w);
    case (w.req_type)
      REQ_SAFE_INIT: begin
        stage.buf_n = 1'b1;
        stage.mode  = MODE_SAFE_INIT;
        stage.fault = FAULT_NONE;
      end
      REQ_PWM_INIT: begin
        if (offer_duty(lim.initial_duty)) begin
          stage.trip  = 1'b1;
          stage.buf_n = 1'b1;
          stage.mode  = MODE_READY;
        end
      end
      REQ_SERVICE: begin
        if (stage.mode == MODE_FAULT) begin
          stage.buf_n = 1'b1;
        end else if (w.stop_request) begin
          trip_stage(1'b0);
        end else if (w.duty_command == stage.last_req || offer_duty(w.duty_command)) begin
          // arming only from ready; trip source sampled here alone
          if (w.arm_request && stage.mode == MODE_READY) begin
            stage.trip = w.trip_source_active;
            if (!w.trip_source_active) begin
              stage.buf_n = 1'b0;
              stage.mode  = MODE_RUNNING;
            end else begin
              stage.buf_n = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    return '{stage.mode, stage.fault, stage.last_req, stage.last_app, stage.cmp,
             stage.trip, stage.buf_n};
  endfunction

  // --------------------------------------------------------------------------
  // Random request words, biased towards sequences that get past init
  // --------------------------------------------------------------------------
  function automatic in_word_t random_request();
    in_word_t         w;
    int unsigned      pick;
    logic [DutyW-1:0] top;
    bit               recover;
    w.arm_request        = ($urandom_range(0, 9) < 4);
    w.stop_request       = ($urandom_range(0, 24) == 0);
    w.trip_source_active = ($urandom_range(0, 9) < 3);
    recover = (stage.mode == MODE_FAULT || stage.mode == MODE_BOOT ||
               stage.mode == MODE_SAFE_INIT) && $urandom_range(0, 2) == 0;
    pick = $urandom_range(0, 99);
    if (pick < 4)                 w.req_type = REQ_UNUSED;
    else if (pick < 9)            w.req_type = REQ_SAFE_INIT;
    else if (pick < 15 || recover) w.req_type = REQ_PWM_INIT;
    else                          w.req_type = REQ_SERVICE;
    top  = (lim.max_duty > DUTY_FULL) ? DUTY_FULL : lim.max_duty;
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w.duty_command = stage.last_req;
    end else if (pick < 80 && lim.min_duty <= top) begin
      w.duty_command = DutyW'($urandom_range(lim.min_duty, top));
    end else if (pick < 90) begin
      case ($urandom_range(0, 6))
        0:       w.duty_command = lim.min_duty;
        1:       w.duty_command = lim.max_duty;
        2:       w.duty_command = lim.min_duty - 1'b1;
        3:       w.duty_command = lim.max_duty + 1'b1;
        4:       w.duty_command = DUTY_FULL;
        5:       w.duty_command = DUTY_FULL + 1'b1;
        default: w.duty_command = '1;
      endcase
    end else begin
      w.duty_command = DutyW'($urandom_range(0, 1023));
    end
    return w;
  endfunction

  // --------------------------------------------------------------------------
  // Request side: all tasks start and end just after a rising edge
  // --------------------------------------------------------------------------
  task automatic hold_off(int unsigned cycles);
    in_valid_i <= 1'b0;
    repeat (cycles) @(posedge clk_i);
  endtask

  // bursts of back-to-back words with short gaps, now and then a long one
  task automatic next_slot();
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      if ($urandom_range(0, 3) != 0)
        hold_off($urandom_range(1, ($urandom_range(0, 7) == 0) ? 30 : 6));
    end
    burst_left--;
  endtask

  task automatic send_word(in_word_t w, logic typed, out_word_t want);
    out_word_t modelled;
    in_valid_i <= 1'b1;
    in_word_i  <= w;
    do @(posedge clk_i); while (in_stall_o);
    modelled = stage_after(w);
    status_due.push_back(typed ? want : modelled);
  endtask

  // sender holds off until every status word is back
  task automatic drain();
    in_valid_i <= 1'b0;
    while (status_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_limits(cfg_t c);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_index_i <= 2'(i);
      case (cfg_idx_e'(i))
        CFG_MIN_DUTY:  cfg_data_i <= PeriodW'(c.min_duty);
        CFG_MAX_DUTY:  cfg_data_i <= PeriodW'(c.max_duty);
        CFG_INIT_DUTY: cfg_data_i <= PeriodW'(c.initial_duty);
        default:       cfg_data_i <= c.period_counts;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    lim = c;
  endtask

  // --------------------------------------------------------------------------
  // Status side: stall pattern in segments of varying style
  // --------------------------------------------------------------------------
  int unsigned stall_style = 0;
  int unsigned stall_left  = 0;

  always @(posedge clk_i) begin
    if (stall_left == 0) begin
      stall_style <= $urandom_range(0, 3);
      stall_left  <= $urandom_range(20, 200);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_style)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= stall_left[3];
    endcase
  end

  function automatic void check_field(string field, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("status word %0d: %s expected %0d, got %0d", words_seen, field, want, got);
    end
  endfunction

  always @(posedge clk_i) begin : watch_status
    out_word_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (status_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("status word %0d arrived with none outstanding: %h", words_seen, out_word_o);
      end else begin
        want = status_due.pop_front();
        check_field("stage_state",     16'(want.stage_state),     16'(out_word_o.stage_state));
        check_field("fault_code",      16'(want.fault_code),      16'(out_word_o.fault_code));
        check_field("requested_duty",  16'(want.requested_duty),  16'(out_word_o.requested_duty));
        check_field("applied_duty",    16'(want.applied_duty),    16'(out_word_o.applied_duty));
        check_field("compare_value",   want.compare_value,        out_word_o.compare_value);
        check_field("trip_flag",       16'(want.trip_flag),       16'(out_word_o.trip_flag));
        check_field("buffer_enable_n", 16'(want.buffer_enable_n), 16'(out_word_o.buffer_enable_n));
      end
      words_seen++;
    end
  end

  // Watchdog: too long without a word moving on either side
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles == QUIET_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    cfg_t c;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (DIRECTED[i]) begin
      next_slot();
      send_word(DIRECTED[i].req, DIRECTED[i].typed, DIRECTED[i].want);
    end

    for (int p = 0; p < 10; p++) begin
      drain();
      if (p < 6) begin
        c = PHASE_LIMITS[p];
      end else begin
        c.min_duty      = DutyW'($urandom_range(0, 500));
        c.max_duty      = DutyW'($urandom_range(c.min_duty, 1000));
        c.initial_duty  = DutyW'($urandom_range(0, 1000));
        c.period_counts = PeriodW'($urandom_range(1, 65535));
      end
      load_limits(c);
      repeat (PHASE_WORDS) begin
        next_slot();
        send_word(random_request(), 1'b0, '0);
      end
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0 && status_due.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
